[design/wst_pkg.sv]
// shared types and constants for the world-to-screen transform
// no dependencies
package wst_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // mode codes
    localparam logic [1:0] MODE_LOAD_ROW   = 2'd0;
    localparam logic [1:0] MODE_LOAD_CAM   = 2'd1;
    localparam logic [1:0] MODE_TRANSFORM  = 2'd2;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         row_index;
        logic signed [31:0] coef_0;
        logic signed [31:0] coef_1;
        logic signed [31:0] coef_2;
        logic signed [31:0] coef_3;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
        logic               w_zero;
    } out_word_t;

endpackage

[design/world_to_screen_transform.sv]
// world-to-screen vertex transform: matrix/camera load, 4x4 multiply, divide by w, viewport map
// depends on wst_pkg
//
// throughput: one word per cycle; the three divides by w are bit-per-stage restoring pipelines
// the whole pipeline holds while a result waits on out_ready
// reset: matrix and camera position clear to zero, pipeline empties
module world_to_screen_transform #(
    parameter int FRAC_BITS   = wst_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = wst_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wst_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wst_pkg::out_word_t out_data
);

    localparam int VW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int QW = VW + 1;           // quotient bits kept
    localparam int RW = VW + 1;           // partial remainder width
    localparam int DW = VW + FRAC_BITS;   // scaled dividend magnitude width
    localparam int PW = 2 * VW;
    localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
    localparam logic signed [63:0] ONE64  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF64 = ONE64 >>> 1;

    function automatic logic signed [VW-1:0] sat_vw(input logic signed [63:0] v);
        logic signed [VW-1:0] r;
        if (v > VMAX64)
            r = VW'(VMAX64);
        else if (v < VMIN64)
            r = VW'(VMIN64);
        else
            r = VW'(v);
        return r;
    endfunction

    logic adv;
    logic accept;

    // architectural state
    logic signed [VW-1:0] mat_reg [16];
    logic signed [VW-1:0] cam_reg [3];

    // stage 1: relative point and matrix snapshot
    logic                 v1_reg;
    logic signed [VW-1:0] rel_reg [3];
    logic signed [VW-1:0] mat1_reg [16];
    logic signed [VW-1:0] rel_next [3];

    // stage 2: raw products
    logic                 v2_reg;
    logic signed [PW-1:0] prod_reg [12];
    logic signed [VW-1:0] col3_reg [4];

    // stage 3: clip coordinates
    logic                 v3_reg;
    logic signed [VW-1:0] clip_reg [4];
    logic signed [VW-1:0] clip_next [4];

    // divider stages, index 0 is the setup stage
    logic          vd_reg   [QW+1];
    logic          wz_reg   [QW+1];
    logic [RW-1:0] dmag_reg [QW+1];
    logic [RW-1:0] rem_reg  [QW+1][3];
    logic [QW-1:0] qd_reg   [QW+1][3];
    logic          neg_reg  [QW+1][3];
    logic          ovf_reg  [QW+1][3];

    logic [RW-1:0] rem0_next [3];
    logic [QW-1:0] qd0_next  [3];
    logic          neg0_next [3];
    logic          ovf0_next [3];
    logic [VW-1:0] wmag;

    logic                out_valid_reg;
    wst_pkg::out_word_t  out_reg;
    wst_pkg::out_word_t  out_next;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    always_comb
    begin
        rel_next[0] = sat_vw(64'(sat_vw(64'(in_data.pos_x))) - 64'(cam_reg[0]));
        rel_next[1] = sat_vw(64'(sat_vw(64'(in_data.pos_y))) - 64'(cam_reg[1]));
        rel_next[2] = sat_vw(64'(sat_vw(64'(in_data.pos_z))) - 64'(cam_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                cam_reg[i] <= '0;
        end
        else if (accept)
        begin
            unique case (in_data.mode)
                wst_pkg::MODE_LOAD_ROW:
                begin
                    mat_reg[{in_data.row_index, 2'd0}] <= sat_vw(64'(in_data.coef_0));
                    mat_reg[{in_data.row_index, 2'd1}] <= sat_vw(64'(in_data.coef_1));
                    mat_reg[{in_data.row_index, 2'd2}] <= sat_vw(64'(in_data.coef_2));
                    mat_reg[{in_data.row_index, 2'd3}] <= sat_vw(64'(in_data.coef_3));
                end
                wst_pkg::MODE_LOAD_CAM:
                begin
                    cam_reg[0] <= sat_vw(64'(in_data.pos_x));
                    cam_reg[1] <= sat_vw(64'(in_data.pos_y));
                    cam_reg[2] <= sat_vw(64'(in_data.pos_z));
                end
                default:
                begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
                vd_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= accept && (in_data.mode == wst_pkg::MODE_TRANSFORM);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int k = 0; k < QW; k++)
                vd_reg[k+1] <= vd_reg[k];
            out_valid_reg <= vd_reg[QW];
        end
    end

    // stages 1 to 3
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            clip_next[r] = sat_vw(64'(col3_reg[r])
                + ((64'(prod_reg[r*3+0]) + HALF64) >>> FRAC_BITS)
                + ((64'(prod_reg[r*3+1]) + HALF64) >>> FRAC_BITS)
                + ((64'(prod_reg[r*3+2]) + HALF64) >>> FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                rel_reg[i] <= rel_next[i];
            for (int i = 0; i < 16; i++)
                mat1_reg[i] <= mat_reg[i];
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r*3+c] <= PW'(mat1_reg[r*4+c]) * PW'(rel_reg[c]);
                col3_reg[r] <= mat1_reg[r*4+3];
                clip_reg[r] <= clip_next[r];
            end
        end
    end

    // divider setup: magnitudes, sign, early overflow on the top dividend bits
    always_comb
    begin
        logic [VW-1:0] amag;
        logic [DW-1:0] num;
        logic [DW-1:0] high;
        wmag = clip_reg[3][VW-1] ? (~clip_reg[3] + 1'b1) : clip_reg[3];
        for (int l = 0; l < 3; l++)
        begin
            amag = clip_reg[l][VW-1] ? (~clip_reg[l] + 1'b1) : clip_reg[l];
            num  = DW'(amag) << FRAC_BITS;
            high = num >> QW;
            ovf0_next[l] = (high >= DW'(wmag));
            rem0_next[l] = RW'(high);
            qd0_next[l]  = num[QW-1:0];
            neg0_next[l] = clip_reg[l][VW-1] ^ clip_reg[3][VW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wz_reg[0]   <= (clip_reg[3] == '0);
            dmag_reg[0] <= RW'(wmag);
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= rem0_next[l];
                qd_reg[0][l]  <= qd0_next[l];
                neg_reg[0][l] <= neg0_next[l];
                ovf_reg[0][l] <= ovf0_next[l];
            end
        end
    end

    // one quotient bit per stage; dividend bits shift out as quotient bits shift in
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [RW-1:0] trial [3];
        logic          ge    [3];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {rem_reg[k][l][RW-2:0], qd_reg[k][l][QW-1]};
                ge[l]    = (trial[l] >= dmag_reg[k]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                wz_reg[k+1]   <= wz_reg[k];
                dmag_reg[k+1] <= dmag_reg[k];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[k+1][l] <= ge[l] ? (trial[l] - dmag_reg[k]) : trial[l];
                    qd_reg[k+1][l]  <= {qd_reg[k][l][QW-2:0], ge[l]};
                    neg_reg[k+1][l] <= neg_reg[k][l];
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end
    end

    // saturate quotients, then viewport map
    always_comb
    begin
        logic signed [63:0]   qz;
        logic signed [VW-1:0] ndc [3];
        for (int l = 0; l < 3; l++)
        begin
            qz = 64'(qd_reg[QW][l]);
            if (!neg_reg[QW][l])
                ndc[l] = (ovf_reg[QW][l] || qz > VMAX64) ? VW'(VMAX64) : VW'(qz);
            else
                ndc[l] = (ovf_reg[QW][l] || qz > (VMAX64 + 64'sd1)) ? VW'(VMIN64) : VW'(-qz);
        end
        if (wz_reg[QW])
        begin
            out_next.screen_x = '0;
            out_next.screen_y = '0;
            out_next.depth    = '0;
            out_next.w_zero   = 1'b1;
        end
        else
        begin
            out_next.screen_x = 32'(sat_vw((64'(ndc[0]) + ONE64) >>> 1));
            out_next.screen_y = 32'(sat_vw((ONE64 - 64'(ndc[1])) >>> 1));
            out_next.depth    = 32'(sat_vw((64'(ndc[2]) + ONE64) >>> 1));
            out_next.w_zero   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[tb/wst_checker.sv]
// transform predictor and result checker for the world-to-screen block
// depends on wst_pkg; watches the input and output channels of the block
module wst_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  wst_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  wst_pkg::out_word_t out_data,
    output int                 fail_count,
    output int                 pending_points,
    output int                 checked_points
);

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;

    longint             matrix_q [16];
    longint             camera_q [3];
    wst_pkg::out_word_t screen_fifo [$];

    function automatic longint clamp32(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // round half up to the fraction width
    function automatic longint fixmul(input longint a, input longint b);
        longint p;
        p = a * b + (ONE >>> 1);
        return p >>> 16;
    endfunction

    function automatic wst_pkg::out_word_t project_point(input wst_pkg::in_word_t w);
        longint             rel [3];
        longint             clip [4];
        longint             ndc [3];
        longint             acc;
        longint             pt [3];
        wst_pkg::out_word_t res;
        pt[0] = longint'(w.pos_x);
        pt[1] = longint'(w.pos_y);
        pt[2] = longint'(w.pos_z);
        for (int i = 0; i < 3; i++) rel[i] = clamp32(pt[i] - camera_q[i]);
        for (int r = 0; r < 4; r++)
        begin
            acc = matrix_q[r*4+3];
            for (int i = 0; i < 3; i++) acc += fixmul(matrix_q[r*4+i], rel[i]);
            clip[r] = clamp32(acc);
        end
        res = '0;
        if (clip[3] == 0)
        begin
            res.w_zero = 1'b1;
            return res;
        end
        // signed divide truncates toward zero
        for (int i = 0; i < 3; i++) ndc[i] = clamp32((clip[i] * ONE) / clip[3]);
        res.screen_x = 32'(clamp32((ndc[0] + ONE) >>> 1));
        res.screen_y = 32'(clamp32((ONE - ndc[1]) >>> 1));
        res.depth    = 32'(clamp32((ndc[2] + ONE) >>> 1));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wst_pkg::out_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) matrix_q[i] = 0;
            for (int i = 0; i < 3; i++) camera_q[i] = 0;
            screen_fifo.delete();
            fail_count     <= 0;
            checked_points <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (screen_fifo.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = screen_fifo.pop_front();
                    if (want !== out_data)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: x %h/%h y %h/%h depth %h/%h wz %b/%b",
                                want.screen_x, out_data.screen_x,
                                want.screen_y, out_data.screen_y,
                                want.depth, out_data.depth,
                                want.w_zero, out_data.w_zero);
                        fail_count <= fail_count + 1;
                    end
                    checked_points <= checked_points + 1;
                end
            end
            if (in_valid && in_ready)
            begin
                case (in_data.mode)
                    wst_pkg::MODE_LOAD_ROW:
                    begin
                        matrix_q[in_data.row_index*4+0] = longint'(in_data.coef_0);
                        matrix_q[in_data.row_index*4+1] = longint'(in_data.coef_1);
                        matrix_q[in_data.row_index*4+2] = longint'(in_data.coef_2);
                        matrix_q[in_data.row_index*4+3] = longint'(in_data.coef_3);
                    end
                    wst_pkg::MODE_LOAD_CAM:
                    begin
                        camera_q[0] = longint'(in_data.pos_x);
                        camera_q[1] = longint'(in_data.pos_y);
                        camera_q[2] = longint'(in_data.pos_z);
                    end
                    wst_pkg::MODE_TRANSFORM: screen_fifo.push_back(project_point(in_data));
                    default: ;
                endcase
            end
        end
    end

    assign pending_points = screen_fifo.size();

endmodule

[tb/tb_world_to_screen_transform.sv]
// stimulus and verdict for the world-to-screen transform
// depends on wst_pkg, world_to_screen_transform and wst_checker
module tb_world_to_screen_transform;

    localparam int LATENCY = 37;
    localparam int LIMIT   = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    wst_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    wst_pkg::out_word_t out_data;
    int                 fail_count;
    int                 pending_points;
    int                 checked_points;
    int                 cycle_count = 0;
    int                 sent_words = 0;
    bit                 hold_off = 1'b0;
    bit                 calm = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    world_to_screen_transform dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    wst_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_points(pending_points),
        .checked_points(checked_points)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls at random, or holds off entirely while asked
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !hold_off && (calm || $urandom_range(99) >= 16);
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
        endcase
    endfunction

    // valid stays high after acceptance unless an idle cycle or a drain follows
    task automatic send_word(input wst_pkg::in_word_t w, input bit no_gaps);
        if (!no_gaps)
            while ($urandom_range(99) < 16)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_words++;
    endtask

    function automatic wst_pkg::in_word_t make_word(input logic [1:0] m, input logic [1:0] r,
                                           input logic [31:0] c0, input logic [31:0] c1,
                                           input logic [31:0] c2, input logic [31:0] c3,
                                           input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz);
        wst_pkg::in_word_t w;
        w.mode = m; w.row_index = r;
        w.coef_0 = c0; w.coef_1 = c1; w.coef_2 = c2; w.coef_3 = c3;
        w.pos_x = px; w.pos_y = py; w.pos_z = pz;
        return w;
    endfunction

    // noise in the unused fields so every bit toggles
    function automatic wst_pkg::in_word_t random_word(input logic [1:0] m);
        return make_word(m, 2'($urandom), pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value(), pick_value(), pick_value());
    endfunction

    // a sane perspective matrix with random scale so w is rarely zero
    task automatic load_projection(input bit no_gaps);
        wst_pkg::in_word_t w;
        for (int r = 0; r < 4; r++)
        begin
            w = random_word(wst_pkg::MODE_LOAD_ROW);
            w.row_index = 2'(r);
            w.coef_0 = (r == 0) ? 32'($urandom_range(3 * 65536)) : 32'($urandom_range(4096));
            w.coef_1 = (r == 1) ? 32'($urandom_range(3 * 65536)) : 32'($urandom_range(4096));
            w.coef_2 = (r == 3) ? -32'sd65536 : 32'($urandom_range(2 * 65536));
            w.coef_3 = (r == 3) ? 32'sd0 : 32'($urandom_range(65536));
            send_word(w, no_gaps);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_points != 0) @(posedge clk);
    endtask

    initial
    begin
        wst_pkg::in_word_t w;
        int                stall;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: point against an all-zero matrix gives the zero w case
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd3, 32'h7fff_ffff, 32'h8000_0000,
                            32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
                            32'h1234_5678), 1'b0);
        // identity matrix with w = 1
        for (int r = 0; r < 4; r++)
            send_word(make_word(wst_pkg::MODE_LOAD_ROW, 2'(r),
                                r == 0 ? 32'sd65536 : 32'sd0, r == 1 ? 32'sd65536 : 32'sd0,
                                r == 2 ? 32'sd65536 : 32'sd0, r == 3 ? 32'sd65536 : 32'sd0,
                                32'hdead_beef, 32'h0, 32'h7fff_ffff), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'sd0, 32'sd0,
                            32'sd0), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000), 1'b0);
        // camera at extremes so the relative point saturates
        send_word(make_word(wst_pkg::MODE_LOAD_CAM, 2'd2, 32'hffff_ffff, 0, 0, 0,
                            32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000), 1'b0);
        // unused mode is ignored
        send_word(make_word(wst_pkg::MODE_UNUSED, 2'd1, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'sd3, 32'sd5,
                            32'sd7), 1'b0);
        // extreme matrix: big products, tiny and negative w
        send_word(make_word(wst_pkg::MODE_LOAD_ROW, 2'd0, 32'h7fff_ffff, 32'h8000_0000,
                            32'h7fff_ffff, 32'h8000_0000, 0, 0, 0), 1'b0);
        send_word(make_word(wst_pkg::MODE_LOAD_ROW, 2'd3, 0, 0, 0, 32'sd1, 0, 0, 0), 1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'sd100, 32'sd2,
                            32'sd9), 1'b0);
        send_word(make_word(wst_pkg::MODE_LOAD_ROW, 2'd3, 0, 0, 0, 32'hffff_ffff, 0, 0, 0),
                  1'b0);
        send_word(make_word(wst_pkg::MODE_TRANSFORM, 2'd0, 0, 0, 0, 0, 32'sd100, 32'sd2,
                            32'sd9), 1'b0);

        // sender pauses until every result is back
        wait_drained();

        // receiver holds off long so the pipeline fills and stalls the input
        hold_off = 1'b1;
        fork
            begin
                for (stall = 0; stall < 200; stall++) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 60; k++)
                send_word(random_word(wst_pkg::MODE_TRANSFORM), 1'b1);
        join

        // random traffic, mostly points through a sane matrix
        for (int k = 0; k < 300; k++)
        begin
            calm = (k >= 150 && k < 230);
            case ($urandom_range(19))
                0: load_projection(calm);
                1: send_word(random_word(wst_pkg::MODE_LOAD_ROW), calm);
                2: send_word(random_word(wst_pkg::MODE_LOAD_CAM), calm);
                3: send_word(random_word(wst_pkg::MODE_UNUSED), calm);
                default:
                begin
                    w = random_word(wst_pkg::MODE_TRANSFORM);
                    if ($urandom_range(3) != 0)
                    begin
                        w.pos_x = 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
                        w.pos_y = 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
                        w.pos_z = 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
                    end
                    send_word(w, calm);
                end
            endcase
        end
        calm = 1'b0;

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d input words and %0d checked screen results",
                 sent_words, checked_points);
        $display("included loads, camera moves, ignored mode, zero w and a long output stall");
        if (fail_count == 0 && pending_points == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
design/wst_pkg.sv
design/world_to_screen_transform.sv
tb/wst_checker.sv
tb/tb_world_to_screen_transform.sv
